// ----- rtl/core/kvt_pkg.sv -----
// kvt_pkg: shared types and codes for the key/value table.
// Request and response payloads, opcodes, status codes, cell control structs.
// No dependencies.
package kvt_pkg;

  localparam int KVT_ENTRIES    = 16;
  localparam int KVT_KEY_BITS   = 32;
  localparam int KVT_VALUE_BITS = 32;

  // opcodes
  localparam logic [1:0] OP_FIND   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // response status codes
  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_INSERTED  = 3'd2;
  localparam logic [2:0] ST_PRESENT   = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_REMOVED   = 3'd5;
  localparam logic [2:0] ST_BAD_SLOT  = 3'd6;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] value;
    logic [3:0]  slot;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  hit_slot;
    logic [31:0] hit_value;
  } rsp_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic       cmp;     // latch per-cell compare results
    logic       upd;     // commit the table update
    logic [1:0] op;
    logic [3:0] slot;
    logic       any_hit; // key present somewhere in the table
  } cell_cmd_t;

  // priority flags rippling down the chain: "seen in an earlier cell"
  typedef struct packed {
    logic hit;
    logic free;
    logic rm;
  } chain_t;

endpackage

// ----- rtl/core/kvt_cell.sv -----
// kvt_cell: one table entry with its own key comparator and chain link.
// Depends on kvt_pkg.
module kvt_cell #(
  parameter int INDEX      = 0,
  parameter int SLOT_W     = 4,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  kvt_pkg::cell_cmd_t    cmd,
  input  logic [KEY_BITS-1:0]   key_in,
  input  logic [VALUE_BITS-1:0] value_in,
  input  kvt_pkg::chain_t       chain_in,
  input  logic [SLOT_W-1:0]     hit_slot_in,
  input  logic [VALUE_BITS-1:0] hit_value_in,
  input  logic [SLOT_W-1:0]     free_slot_in,
  output kvt_pkg::chain_t       chain_out,
  output logic [SLOT_W-1:0]     hit_slot_out,
  output logic [VALUE_BITS-1:0] hit_value_out,
  output logic [SLOT_W-1:0]     free_slot_out
);
  import kvt_pkg::*;

  localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

  logic                  valid;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;
  logic                  hit_q;
  logic                  free_q;
  logic                  rm_q;
  logic                  slot_sel;
  logic                  take_insert;

  assign slot_sel = (32'(cmd.slot) == INDEX);

  // compare results, latched once per request
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_q  <= 1'b0;
      free_q <= 1'b0;
      rm_q   <= 1'b0;
    end else if (cmd.cmp) begin
      hit_q  <= valid && (key == key_in);
      free_q <= !valid;
      rm_q   <= valid && slot_sel;
    end
  end

  // first hit / first free cell wins; later cells pass through
  assign chain_out.hit  = chain_in.hit  | hit_q;
  assign chain_out.free = chain_in.free | free_q;
  assign chain_out.rm   = chain_in.rm   | rm_q;

  assign hit_slot_out  = (hit_q && !chain_in.hit) ? MY_SLOT : hit_slot_in;
  assign hit_value_out = (hit_q && !chain_in.hit) ? value   : hit_value_in;
  assign free_slot_out = (free_q && !chain_in.free) ? MY_SLOT : free_slot_in;

  assign take_insert = (cmd.op == OP_INSERT) && !cmd.any_hit && free_q && !chain_in.free;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.upd) begin
      case (cmd.op)
        OP_INSERT: begin
          if (take_insert) begin
            valid <= 1'b1;
          end
        end
        OP_REMOVE: begin
          if (rm_q) begin
            valid <= 1'b0;
          end
        end
        OP_CLEAR: begin
          valid <= 1'b0;
        end
        default: begin
          valid <= valid;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd && take_insert) begin
      key   <= key_in;
      value <= value_in;
    end
  end

endmodule

// ----- rtl/core/key_value_table.sv -----
// key_value_table: fixed-capacity associative table of unique keys (CAM).
// Top level: request register, two-step controller, response register and
// a chain of kvt_cell entries. Depends on kvt_pkg and kvt_cell.
//
//   channel | signals                    | payload
//   --------+----------------------------+----------------------------------
//   request | req_valid / req_ready      | req : op, key, value, slot
//   result  | rsp_valid / rsp_ready      | rsp : status, hit_slot, hit_value
//
// Steps: a request is taken in the idle step, then passes through the compare
//   step (compare in every cell) and the commit step (resolve the first hit /
//   first free cell along the chain and commit). The result is registered in
//   the response register when the commit fires, and a new request is taken
//   only once the block is back in the idle step.
// The resolve step ripples combinationally through all ENTRIES cells.
// Reset clears every valid bit at once; key and value storage is not reset.
// A stalled result holds the block in the commit step, but a finished result
//   waiting in the response register does not block the next request.
module key_value_table #(
  parameter int ENTRIES    = kvt_pkg::KVT_ENTRIES,
  parameter int KEY_BITS   = kvt_pkg::KVT_KEY_BITS,
  parameter int VALUE_BITS = kvt_pkg::KVT_VALUE_BITS
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  kvt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output kvt_pkg::rsp_t rsp
);
  import kvt_pkg::*;

  localparam int SLOT_W = $clog2(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_UPD  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  req_t req_q;        // request held for both steps
  rsp_t res;          // result of the commit step
  logic upd_fire;

  logic [KEY_BITS-1:0]   key_in;
  logic [VALUE_BITS-1:0] value_in;

  cell_cmd_t cmd;

  // chain links; link 0 is the head (nothing seen yet)
  chain_t                chain     [ENTRIES+1];
  logic [SLOT_W-1:0]     hit_slot  [ENTRIES+1];
  logic [VALUE_BITS-1:0] hit_value [ENTRIES+1];
  logic [SLOT_W-1:0]     free_slot [ENTRIES+1];

  logic [3:0]  hit_slot4;
  logic [3:0]  free_slot4;
  logic [31:0] hit_value32;
  logic [31:0] value32;

  // ---------------------------------------------------------------------
  // field width adaptation: keys and values keep their low bits,
  // reported values are zero-extended or truncated to 32 bits
  // ---------------------------------------------------------------------
  assign key_in      = KEY_BITS'(req_q.key);
  assign value_in    = VALUE_BITS'(req_q.value);
  assign hit_value32 = 32'(hit_value[ENTRIES]);
  assign value32     = 32'(value_in);

  // reported slot numbers are zero-extended or truncated to the low 4 bits
  if (SLOT_W >= 4) begin : g_slot_wide
    assign hit_slot4  = hit_slot[ENTRIES][3:0];
    assign free_slot4 = free_slot[ENTRIES][3:0];
  end else begin : g_slot_narrow
    assign hit_slot4  = {{(4-SLOT_W){1'b0}}, hit_slot[ENTRIES]};
    assign free_slot4 = {{(4-SLOT_W){1'b0}}, free_slot[ENTRIES]};
  end

  // ---------------------------------------------------------------------
  // controller
  // ---------------------------------------------------------------------
  assign req_ready = (state == S_IDLE);
  // commit only when the response register can take the result
  assign upd_fire  = (state == S_UPD) && (!rsp_valid || rsp_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (upd_fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
  end

  assign cmd.cmp     = (state == S_CMP);
  assign cmd.upd     = upd_fire;
  assign cmd.op      = req_q.op;
  assign cmd.slot    = req_q.slot;
  assign cmd.any_hit = chain[ENTRIES].hit;

  // ---------------------------------------------------------------------
  // cell chain
  // ---------------------------------------------------------------------
  assign chain[0]     = '0;
  assign hit_slot[0]  = '0;
  assign hit_value[0] = '0;
  assign free_slot[0] = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    kvt_cell #(
      .INDEX      (i),
      .SLOT_W     (SLOT_W),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk           (clk),
      .rst           (rst),
      .cmd           (cmd),
      .key_in        (key_in),
      .value_in      (value_in),
      .chain_in      (chain[i]),
      .hit_slot_in   (hit_slot[i]),
      .hit_value_in  (hit_value[i]),
      .free_slot_in  (free_slot[i]),
      .chain_out     (chain[i+1]),
      .hit_slot_out  (hit_slot[i+1]),
      .hit_value_out (hit_value[i+1]),
      .free_slot_out (free_slot[i+1])
    );
  end

  // ---------------------------------------------------------------------
  // result decode from the chain tail
  // ---------------------------------------------------------------------
  always_comb begin
    res = '0;
    case (req_q.op)
      OP_FIND: begin
        if (chain[ENTRIES].hit) begin
          res.status    = ST_FOUND;
          res.hit_slot  = hit_slot4;
          res.hit_value = hit_value32;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      OP_INSERT: begin
        if (chain[ENTRIES].hit) begin
          res.status    = ST_PRESENT;
          res.hit_slot  = hit_slot4;
          res.hit_value = hit_value32;
        end else if (chain[ENTRIES].free) begin
          res.status    = ST_INSERTED;
          res.hit_slot  = free_slot4;
          res.hit_value = value32;
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_REMOVE: begin
        // slots beyond the table never match a cell, so they report bad slot
        res.status = chain[ENTRIES].rm ? ST_REMOVED : ST_BAD_SLOT;
      end
      OP_CLEAR: begin
        res.status = ST_REMOVED;
      end
      default: begin
        res.status = ST_BAD_SLOT;
      end
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (upd_fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      rsp <= res;
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_accept_to_cmp: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_CMP))
    else $error("accepted request did not enter compare step");

  a_cmp_to_upd: assert property (@(posedge clk) disable iff (rst)
    (state == S_CMP) |=> (state == S_UPD))
    else $error("compare step not followed by commit step");

  a_commit_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    upd_fire |=> (rsp_valid && (state == S_IDLE)))
    else $error("commit did not produce a response");

  a_full_no_insert: assert property (@(posedge clk) disable iff (rst)
    ((state == S_UPD) && !chain[ENTRIES].free) |-> (res.status != ST_INSERTED))
    else $error("insert reported with no free cell");

endmodule
